[sv/pqlde_pkg.sv]
// Shared types and constants for the PQ lookup-table distance estimator.
// No dependencies; every other file except pqlde_ram imports this package.
package pqlde_pkg;

    localparam int LANES     = 16;
    localparam int CODE_BITS = 8;
    localparam int DIST_BITS = 36;
    localparam int ID_BITS   = 31;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_SCORE = 2'd1,
        ACT_SWAP  = 2'd2
    } action_t;

    typedef struct packed {
        logic [1:0]   action;
        logic [7:0]   lut_row;
        logic [3:0]   lut_subspace;
        logic [31:0]  lut_value;
        logic [63:0]  codes_low;
        logic [63:0]  codes_high;
        logic [30:0]  vector_id;
        logic         is_padding;
    } item_t;

    typedef struct packed {
        logic signed [31:0] result_id;
        logic [35:0]        distance;
    } result_t;

    // write control for one lane's table memory
    typedef struct packed {
        logic       en;
        logic       bank;
        logic [7:0] row;
    } lut_wr_t;

    // read control shared by all lanes
    typedef struct packed {
        logic en;
        logic bank;
    } lut_rd_t;

    // score bookkeeping that travels beside the lane data
    typedef struct packed {
        logic               valid;
        logic               pad;
        logic [ID_BITS-1:0] id;
    } score_tag_t;

endpackage

[sv/pqlde_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pqlde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[sv/pqlde_lane.sv]
// One subspace lane: both table banks of one column in a single RAM,
// bank select as the top address bit. Uses pqlde_pkg and pqlde_ram.
module pqlde_lane import pqlde_pkg::*; #(
    parameter int TABLE_ROWS = 256,
    parameter int ENTRY_BITS = 32
) (
    input  logic                  clk,
    input  lut_wr_t               wr,
    input  logic [ENTRY_BITS-1:0] wr_value,
    input  lut_rd_t               rd,
    input  logic [CODE_BITS-1:0]  code,
    output logic [ENTRY_BITS-1:0] entry
);

    localparam int ROW_BITS = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
    localparam int DEPTH    = 2 * (1 << ROW_BITS);

    logic                  code_ok;
    logic                  code_ok_reg;
    logic [ENTRY_BITS-1:0] rd_data;

    // codes beyond the table contribute nothing
    assign code_ok = ({1'b0, code} < (CODE_BITS + 1)'(TABLE_ROWS));

    pqlde_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr.en),
        .wr_addr ({wr.bank, wr.row[ROW_BITS-1:0]}),
        .wr_data (wr_value),
        .rd_en   (rd.en),
        .rd_addr ({rd.bank, code[ROW_BITS-1:0]}),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            code_ok_reg <= code_ok;
        end
    end

    assign entry = code_ok_reg ? rd_data : '0;

endmodule

[sv/pqlde_merge.sv]
// Merge stage: two-level registered adder tree over the lane entries and
// the output word register with the padding substitution. Uses pqlde_pkg.
module pqlde_merge import pqlde_pkg::*; #(
    parameter int ENTRY_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             advance,
    input  logic [LANES-1:0][ENTRY_BITS-1:0] entries,
    input  score_tag_t                       tag,
    input  logic [DIST_BITS-1:0]             large_distance,
    output logic                             result_valid,
    output result_t                          result
);

    localparam int GROUPS    = LANES / 4;
    localparam int PART_BITS = ENTRY_BITS + 2;
    localparam int SUM_BITS  = ENTRY_BITS + 4;

    logic [GROUPS-1:0][PART_BITS-1:0] part_next;
    logic [GROUPS-1:0][PART_BITS-1:0] part_reg;
    score_tag_t                       tag_reg;
    logic [SUM_BITS-1:0]              sum;
    logic                             result_valid_reg;
    result_t                          result_reg;

    always_comb
    begin
        for (int j = 0; j < GROUPS; j++)
        begin
            part_next[j] = PART_BITS'(entries[4*j])     + PART_BITS'(entries[4*j + 1])
                         + PART_BITS'(entries[4*j + 2]) + PART_BITS'(entries[4*j + 3]);
        end
    end

    assign sum = SUM_BITS'(part_reg[0]) + SUM_BITS'(part_reg[1])
               + SUM_BITS'(part_reg[2]) + SUM_BITS'(part_reg[3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            tag_reg          <= tag;
            result_valid_reg <= tag_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            part_reg <= part_next;
            if (tag_reg.pad)
            begin
                result_reg.result_id <= '1;
                result_reg.distance  <= large_distance;
            end
            else
            begin
                result_reg.result_id <= {1'b0, tag_reg.id};
                result_reg.distance  <= DIST_BITS'(sum);
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // a scored sum never exceeds sixteen full-scale entries
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_reg.result_id[31]
        |-> (result_reg.distance >> SUM_BITS) == '0)
        else $error("scored distance wider than the lane sum");

    // a stalled output word keeps its slot until the next advance
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(result_valid_reg) && $stable(tag_reg.valid))
        else $error("merge pipeline moved during a stall");

endmodule

[sv/pq_lut_distance_estimator.sv]
// A score word's result passes through the table read, the first adder level and
// the output register before it is valid.
// Throughput: one word per cycle; the whole pipeline holds while a finished
// result waits on result_ready, so the output register sets the pace.
// Load and swap words produce no result.
// Reset clears the pipeline, selects bank a for filling and sets
// large_distance to all ones; table contents are undefined until loaded.
module pq_lut_distance_estimator import pqlde_pkg::*; #(
    parameter int TABLE_ROWS = 256,
    parameter int ENTRY_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  item_t                item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result,
    input  logic                 cfg_wr_en,
    input  logic [DIST_BITS-1:0] cfg_wr_data
);

    logic                             advance;
    logic                             accept;
    logic                             do_load;
    logic                             do_score;
    logic                             do_swap;
    logic                             row_ok;
    logic                             fill_bank_reg;
    logic                             fill_bank_next;
    logic [DIST_BITS-1:0]             large_distance_reg;
    score_tag_t                       tag_reg;
    lut_rd_t                          rd;
    logic [2*LANES*CODE_BITS/2-1:0]   codes;
    logic [LANES-1:0][ENTRY_BITS-1:0] entries;

    // hold everything while the output word is not taken
    assign advance    = !result_valid || result_ready;
    assign item_ready = advance;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        do_load  = 1'b0;
        do_score = 1'b0;
        do_swap  = 1'b0;
        unique case (item.action)
            ACT_LOAD:  do_load  = accept;
            ACT_SCORE: do_score = accept;
            ACT_SWAP:  do_swap  = accept;
            default:   ;
        endcase
    end

    assign row_ok         = ({1'b0, item.lut_row} < (CODE_BITS + 1)'(TABLE_ROWS));
    assign fill_bank_next = fill_bank_reg ^ do_swap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_bank_reg      <= 1'b0;
            large_distance_reg <= '1;
            tag_reg            <= '0;
        end
        else
        begin
            fill_bank_reg <= fill_bank_next;
            if (cfg_wr_en)
            begin
                large_distance_reg <= cfg_wr_data;
            end
            if (advance)
            begin
                tag_reg.valid <= do_score;
                tag_reg.pad   <= item.is_padding;
                tag_reg.id    <= item.vector_id;
            end
        end
    end

    // scores read the active bank, the one not being filled
    assign rd.en   = advance;
    assign rd.bank = ~fill_bank_reg;
    assign codes   = {item.codes_high, item.codes_low};

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        lut_wr_t wr;

        assign wr.en   = do_load && row_ok && (item.lut_subspace == 4'(i));
        assign wr.bank = fill_bank_reg;
        assign wr.row  = item.lut_row;

        pqlde_lane #(
            .TABLE_ROWS (TABLE_ROWS),
            .ENTRY_BITS (ENTRY_BITS)
        ) u_lane (
            .clk      (clk),
            .wr       (wr),
            .wr_value (item.lut_value[ENTRY_BITS-1:0]),
            .rd       (rd),
            .code     (codes[i*CODE_BITS +: CODE_BITS]),
            .entry    (entries[i])
        );
    end

    pqlde_merge #(
        .ENTRY_BITS (ENTRY_BITS)
    ) u_merge (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .entries        (entries),
        .tag            (tag_reg),
        .large_distance (large_distance_reg),
        .result_valid   (result_valid),
        .result         (result)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        do_swap |=> fill_bank_reg != $past(fill_bank_reg))
        else $error("swap did not exchange the banks");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && !do_score |=> !tag_reg.valid)
        else $error("non-score word entered the score pipeline");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.result_id[31] |-> result.distance == large_distance_reg)
        else $error("padded result without the large distance");

    assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> fill_bank_reg == $past(fill_bank_reg))
        else $error("bank select changed without a swap");

endmodule

[test/pq_lut_distance_estimator_check.sv]
`timescale 1ns / 100ps
// Checker for pq_lut_distance_estimator: watches the item, result and config ports,
// keeps its own copy of both table banks and predicts every score result in order.
// Depends on pqlde_pkg for the word types and action codes.
module pq_lut_distance_estimator_check import pqlde_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 item_ready,
    input  item_t                item,
    input  logic                 result_valid,
    input  logic                 result_ready,
    input  result_t              result,
    input  logic                 cfg_wr_en,
    input  logic [DIST_BITS-1:0] cfg_wr_data,
    output int                   fail_count,
    output int                   pending
);

    localparam int TABLE_ROWS   = 256;
    localparam int REPORT_LIMIT = 10;

    logic [31:0]          lut_mem [0:1][0:4095];
    logic                 fill_bank;
    logic [DIST_BITS-1:0] large_dist;
    result_t              expected_q [$];

    // Sum the active-bank entries picked by the 16 codes, or report padding.
    function automatic result_t score_word(input item_t w);
        result_t              r;
        logic [DIST_BITS-1:0] sum;
        logic [7:0]           code;
        logic [3:0]           sub;
        int                   s;
        if (w.is_padding)
        begin
            r.result_id = -32'sd1;
            r.distance  = large_dist;
        end
        else
        begin
            sum = '0;
            for (s = 0; s < LANES; s++)
            begin
                sub  = s[3:0];
                code = (s < 8) ? w.codes_low[8*s +: 8] : w.codes_high[8*(s-8) +: 8];
                if (int'(code) < TABLE_ROWS)
                    sum += DIST_BITS'(lut_mem[~fill_bank][{code, sub}]);
            end
            r.result_id = {1'b0, w.vector_id};
            r.distance  = sum;
        end
        return r;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            fill_bank  = 1'b0;
            large_dist = '1;
            expected_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_q.size() == 0)
                    note_failure($sformatf("unexpected result: id %0d distance %0h",
                                           result.result_id, result.distance));
                else
                begin
                    want = expected_q.pop_front();
                    if (result.result_id !== want.result_id || result.distance !== want.distance)
                        note_failure($sformatf(
                            "mismatch: expected id %0d distance %0h, got id %0d distance %0h",
                            want.result_id, want.distance, result.result_id, result.distance));
                end
            end
            if (item_valid && item_ready)
            begin
                case (item.action)
                    ACT_LOAD:
                        if (int'(item.lut_row) < TABLE_ROWS)
                            lut_mem[fill_bank][{item.lut_row, item.lut_subspace}] = item.lut_value;
                    ACT_SWAP:
                        fill_bank = ~fill_bank;
                    ACT_SCORE:
                        expected_q.push_back(score_word(item));
                    default:
                        ;
                endcase
            end
            if (cfg_wr_en)
                large_dist = cfg_wr_data;
            pending = expected_q.size();
        end
    end

endmodule

[test/pq_lut_distance_estimator_test.sv]
`timescale 1ns / 100ps
// Top of the pq_lut_distance_estimator test: clock, reset, table-load/swap/score stimulus,
// random idling on both channels and the verdict. Needs pqlde_pkg, the block and its checker.
module pq_lut_distance_estimator_test;
    import pqlde_pkg::*;

    localparam logic [1:0] ACT_UNUSED    = 2'd3;
    localparam int         IDLE_PCT      = 31;
    localparam int         ITEM_TARGET   = 1450;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         CALM_FIRST    = 600;
    localparam int         CALM_LAST     = 850;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_ready;
    item_t                item;
    logic                 result_valid;
    logic                 result_ready;
    result_t              result;
    logic                 cfg_wr_en;
    logic [DIST_BITS-1:0] cfg_wr_data;
    int                   fail_count;
    int                   pending;

    // stimulus-side view of the banks, so no score reads an unwritten entry
    bit                   written_map [0:1][0:4095];
    bit                   fill_sel;
    int                   sent_items;
    bit                   steady;
    int                   hold_asks;

    pq_lut_distance_estimator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    pq_lut_distance_estimator_check checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #400000;
        $display("pq_lut_distance_estimator_test: FAIL");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off per request.
    initial
    begin
        int holds_served;
        holds_served = 0;
        result_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_asks != holds_served)
            begin
                holds_served++;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                result_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    function automatic item_t random_word();
        item_t w;
        w.action       = 2'($urandom);
        w.lut_row      = 8'($urandom);
        w.lut_subspace = 4'($urandom);
        w.lut_value    = $urandom;
        w.codes_low    = {$urandom, $urandom};
        w.codes_high   = {$urandom, $urandom};
        w.vector_id    = 31'($urandom);
        w.is_padding   = 1'($urandom);
        return w;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Offer one word and hold it until accepted; valid stays high for a following word.
    task automatic send_word(input item_t w);
        if (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < IDLE_PCT)
                @(posedge clk);
        end
        item       <= w;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        sent_items++;
        steady = (sent_items >= CALM_FIRST && sent_items < CALM_LAST);
    endtask

    task automatic load_entry(input logic [7:0] row, input logic [3:0] sub,
                              input logic [31:0] value);
        item_t w;
        w              = random_word();
        w.action       = ACT_LOAD;
        w.lut_row      = row;
        w.lut_subspace = sub;
        w.lut_value    = value;
        written_map[fill_sel][{row, sub}] = 1'b1;
        send_word(w);
    endtask

    task automatic swap_banks();
        item_t w;
        w        = random_word();
        w.action = ACT_SWAP;
        fill_sel = ~fill_sel;
        send_word(w);
    endtask

    task automatic send_unused();
        item_t w;
        w        = random_word();
        w.action = ACT_UNUSED;
        send_word(w);
    endtask

    // Pick each code among rows written in the active bank; fall back to padding otherwise.
    task automatic score_vector(input logic [30:0] id, input bit pad);
        item_t        w;
        logic [127:0] codes;
        logic [7:0]   r;
        logic [3:0]   sub;
        bit           found;
        int           s;
        int           k;
        w            = random_word();
        w.action     = ACT_SCORE;
        w.vector_id  = id;
        w.is_padding = pad;
        if (!pad)
        begin
            codes = '0;
            for (s = 0; s < LANES; s++)
            begin
                sub   = s[3:0];
                found = 1'b0;
                r     = 8'($urandom_range(0, 255));
                for (k = 0; k < 256 && !found; k++)
                begin
                    if (written_map[~fill_sel][{r, sub}])
                        found = 1'b1;
                    else
                        r++;
                end
                if (!found)
                    w.is_padding = 1'b1;
                codes[8*s +: 8] = r;
            end
            w.codes_low  = codes[63:0];
            w.codes_high = codes[127:64];
        end
        send_word(w);
    endtask

    // Stop offering and wait until every result is back and loads have settled.
    task automatic drain_block();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_large_distance(input logic [DIST_BITS-1:0] value);
        drain_block();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        int cell_num;
        int n;
        int k;
        int s;
        rst_n       <= 1'b0;
        item_valid  <= 1'b0;
        item        <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        fill_sel    = 1'b0;
        sent_items  = 0;
        steady      = 1'b0;
        hold_asks   = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every column at its largest entry gives the widest sum.
        for (s = 0; s < LANES; s++)
            load_entry(8'hff, s[3:0], '1);
        swap_banks();
        score_vector('1, 1'b0);
        score_vector('0, 1'b1);
        send_unused();
        score_vector('0, 1'b0);
        set_large_distance('0);
        score_vector(31'($urandom), 1'b1);

        // Random cells: fill, swap, then score the new active bank, mixed with loads and swaps.
        cell_num = 0;
        while (sent_items < ITEM_TARGET)
        begin
            for (s = 0; s < LANES; s++)
                load_entry(8'($urandom_range(0, 255)), s[3:0], pick_value());
            n = $urandom_range(0, 40);
            repeat (n)
                load_entry(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)), pick_value());
            swap_banks();
            if (cell_num == 2)
                hold_asks++;
            n = $urandom_range(15, 60);
            repeat (n)
            begin
                k = $urandom_range(0, 99);
                if (k < 6)
                    load_entry(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                               pick_value());
                else if (k < 9)
                    send_unused();
                else if (k < 10)
                    swap_banks();
                else
                    score_vector(31'($urandom), k < 18);
            end
            cell_num++;
            if (cell_num % 4 == 0)
            begin
                case ((cell_num / 4) % 4)
                    0:       set_large_distance('0);
                    1:       set_large_distance('1);
                    2:       set_large_distance(DIST_BITS'({$urandom, $urandom}));
                    default: drain_block();
                endcase
            end
        end

        drain_block();
        if (fail_count == 0)
            $display("pq_lut_distance_estimator_test: PASS");
        else
            $display("pq_lut_distance_estimator_test: FAIL");
        $finish;
    end

endmodule

[filelist.f]
sv/pqlde_pkg.sv
sv/pqlde_ram.sv
sv/pqlde_lane.sv
sv/pqlde_merge.sv
sv/pq_lut_distance_estimator.sv
test/pq_lut_distance_estimator_check.sv
test/pq_lut_distance_estimator_test.sv
